// ===== hw/rtl/dgab_pkg.sv =====
// Shared constants for the diagonal gradient alpha blend block.
// No dependencies; imported by dgab_div and diagonal_gradient_alpha_blend.
`default_nettype none

package dgab_pkg;

  // Pixel channel width and quotient steps of the divider
  localparam int PIX_W = 8;

  // Configuration register file
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  // Default largest frame dimension
  localparam int DEF_MAX_DIM = 4096;

endpackage

`default_nettype wire

// ===== hw/rtl/dgab_div.sv =====
// Restoring divider producing a PIX_W-bit quotient, one bit per cycle.
// Depends on dgab_pkg for PIX_W.
`default_nettype none

module dgab_div
  import dgab_pkg::*;
#(
  parameter int TOT_W = 14
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [TOT_W+PIX_W-1:0] num,
  input  wire logic [TOT_W-1:0]       den,
  output logic                        done,
  output logic [PIX_W-1:0]            quo
);

  localparam int NUM_W = TOT_W + PIX_W;
  localparam int STP_W = $clog2(PIX_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r;
  logic [PIX_W-1:0] quo_r;
  logic [STP_W-1:0] step_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  // One trial subtraction of the shifted divisor per cycle
  assign ge      = (rem_r >= dsh_r);
  assign rem_nxt = ge ? (rem_r - dsh_r) : rem_r;

  // Sequencing: load on start, then PIX_W iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == STP_W'(PIX_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STP_W'(1);
        if (step_r == STP_W'(PIX_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {1'b0, den, (PIX_W-1)'(0)};
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[PIX_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/diagonal_gradient_alpha_blend.sv =====
// Top level of the diagonal gradient alpha blend block.
// Depends on dgab_pkg and dgab_div.
//
// Blends one RGB base pixel with one RGB watermark pixel per request, in
// raster order, weighting the watermark by (x+y)/(W+H) along the diagonal
// with exact truncating integer math. Each request goes from acceptance
// to a result in the output register in steps: for each of the three
// channels, state S_MUL forms the weighted sum and S_DIV runs the
// shared bit-serial divider (8 quotient bits plus handoff), then S_OUT
// loads the output register, waiting while it holds an untaken result.
// A new pixel is taken only once the last one has left S_OUT. The input
// is not ready while a pixel is in work; a finished result waits in the
// output register while the next pixel is taken. A write to frame_width
// or frame_height restarts the frame at column 0, row 0; a dimension of
// 0 acts as 1 and one above MAX_DIM acts as MAX_DIM.
`default_nettype none

module diagonal_gradient_alpha_blend
  import dgab_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  // pixel requests
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_base_red,
  input  wire logic [PIX_W-1:0]     in_base_green,
  input  wire logic [PIX_W-1:0]     in_base_blue,
  input  wire logic [PIX_W-1:0]     in_mark_red,
  input  wire logic [PIX_W-1:0]     in_mark_green,
  input  wire logic [PIX_W-1:0]     in_mark_blue,
  // blended results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_blend_red,
  output logic [PIX_W-1:0]          out_blend_green,
  output logic [PIX_W-1:0]          out_blend_blue,
  output logic                      out_end_of_frame
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int TOT_W = $clog2(2 * MAX_DIM + 1);
  localparam int NUM_W = TOT_W + PIX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [1:0] CH_LAST = 2'd2;

  logic [CFG_W-1:0] fw_r, fh_r;
  logic [CNT_W-1:0] col_r, row_r;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [TOT_W-1:0] tot;
  logic             last_col, last_row;
  logic             accept;

  logic [1:0]       state_r;
  logic [1:0]       ch_r;
  logic [TOT_W-1:0] wgt_r;
  logic             eof_r;
  logic [PIX_W-1:0] base_r [3];
  logic [PIX_W-1:0] mark_r [3];
  logic [PIX_W-1:0] res_r  [3];

  logic [NUM_W-1:0] num;
  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] div_quo;
  logic             out_load;

  // Effective frame dimensions: zero acts as one, clamp at MAX_DIM
  always_comb begin
    priority if (fw_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(fw_r) > 32'(MAX_DIM)) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = DIM_W'(fw_r);
    end
    priority if (fh_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(fh_r) > 32'(MAX_DIM)) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = DIM_W'(fh_r);
    end
  end

  assign tot      = TOT_W'(w_eff) + TOT_W'(h_eff);
  assign last_col = ((DIM_W + 1)'(col_r) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(w_eff);
  assign last_row = ((DIM_W + 1)'(row_r) + (DIM_W + 1)'(1)) >= (DIM_W + 1)'(h_eff);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Configuration registers and raster position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= FRAME_WIDTH_RST;
      fh_r  <= FRAME_HEIGHT_RST;
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we && (cfg_index == REG_FRAME_WIDTH ||
                            cfg_index == REG_FRAME_HEIGHT)) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        fw_r <= cfg_wdata;
      end else begin
        fh_r <= cfg_wdata;
      end
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  // Capture the request and its diagonal weight
  always_ff @(posedge clk) begin
    if (accept) begin
      base_r[0] <= in_base_red;
      base_r[1] <= in_base_green;
      base_r[2] <= in_base_blue;
      mark_r[0] <= in_mark_red;
      mark_r[1] <= in_mark_green;
      mark_r[2] <= in_mark_blue;
      wgt_r     <= TOT_W'(col_r) + TOT_W'(row_r);
      eof_r     <= last_col && last_row;
    end
  end

  // Weighted sum of the current channel, loaded straight into the divider
  assign num = NUM_W'(wgt_r) * NUM_W'(mark_r[ch_r])
             + NUM_W'(tot - wgt_r) * NUM_W'(base_r[ch_r]);

  assign div_start = (state_r == S_MUL);

  dgab_div #(
    .TOT_W (TOT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (tot),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid || out_ready);

  // Channel sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MUL;
            ch_r    <= '0;
          end
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (ch_r == CH_LAST) begin
              state_r <= S_OUT;
            end else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Per-channel quotients
  always_ff @(posedge clk) begin
    if (state_r == S_DIV && div_done) begin
      res_r[ch_r] <= div_quo;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blend_red    <= res_r[0];
      out_blend_green  <= res_r[1];
      out_blend_blue   <= res_r[2];
      out_end_of_frame <= eof_r;
    end
  end

endmodule

`default_nettype wire
